// ===== design/bmp_pkg.sv =====
package bmp_pkg;

    // field widths
    localparam int VAL_W     = 30;
    localparam int N_W       = 12;
    localparam int ST_W      = 2;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int EXP_BITS  = 30;
    localparam int EXP_BIT_W = 5;

    localparam int DEFAULT_TABLE_DEPTH = 4096;

    // modulus and fermat exponent
    localparam logic [VAL_W-1:0] PRIME_MOD  = 30'd998244353;
    localparam logic [VAL_W-1:0] FERMAT_EXP = PRIME_MOD - 30'd2;

    // barrett reciprocal floor(2^60 / p) and the bound on the unreduced remainder
    localparam logic [30:0] BARRETT_MU    = 31'((64'd1 << PROD_W) / 64'(PRIME_MOD));
    localparam logic [31:0] BARRETT_LIMIT = 32'(PRIME_MOD) * 32'd3;

    typedef enum logic {
        OP_BUILD = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_BUILT = 2'd1,
        ST_K_GT_N    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MS_ACC_IDX,
        MS_ACC_BASE,
        MS_BASE_BASE
    } t_mul_sel;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_FACT_ISSUE,
        S_FACT_WAIT,
        S_EXP_INIT,
        S_EXP_TEST,
        S_EMUL_ISSUE,
        S_EMUL_WAIT,
        S_ESQR_ISSUE,
        S_ESQR_WAIT,
        S_INV_INIT,
        S_INV_ISSUE,
        S_INV_WAIT,
        S_Q_READ_A,
        S_Q_READ_B,
        S_Q_MUL1_ISSUE,
        S_Q_MUL1_WAIT,
        S_Q_MUL2_ISSUE,
        S_Q_MUL2_WAIT,
        S_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     load_req;
        logic     decode;
        logic     build_init;
        logic     exp_init;
        logic     inv_init;
        logic     mul_start;
        t_mul_sel mul_sel;
        logic     acc_mul;
        logic     base_mul;
        logic     idx_inc;
        logic     idx_dec;
        logic     bit_inc;
        logic     fact_wr;
        logic     inv_wr;
        logic     q_read_a;
        logic     q_read_b;
        logic     q_cap_base;
        logic     set_value;
        logic     push_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_query;
        logic n_beyond;
        logic k_gt_n;
        logic req_top_zero;
        logic top_zero;
        logic idx_eq_top;
        logic idx_is_one;
        logic exp_bit;
        logic bit_last;
        logic mul_done;
        logic out_free;
    } t_sts;

endpackage

// ===== design/bmp_ram.sv =====
module bmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bmp_mulmod.sv =====
module bmp_mulmod
    import bmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_done,
    output logic [VAL_W-1:0] o_res
);

    // five stage barrett reduction: product, quotient estimate, remainder, two corrections
    logic [4:0]        r_vld, n_vld;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [31:0]       r_plo, n_plo;
    logic [30:0]       r_q, n_q;
    logic [31:0]       r_rem, n_rem;
    logic [31:0]       r_rem2, n_rem2;
    logic [VAL_W-1:0]  r_res, n_res;
    logic [61:0]       w_qprod;
    logic [31:0]       w_qp;

    always_comb begin
        n_vld   = {r_vld[3:0], i_start};
        n_prod  = PROD_W'(i_a) * PROD_W'(i_b);
        w_qprod = 62'(r_prod[PROD_W-1:VAL_W-1]) * 62'(BARRETT_MU);
        n_q     = w_qprod[61:31];
        n_plo   = r_prod[31:0];
        w_qp    = 32'(r_q) * 32'(PRIME_MOD);
        n_rem   = r_plo - w_qp;
        n_rem2  = (r_rem >= 32'(PRIME_MOD)) ? r_rem - 32'(PRIME_MOD) : r_rem;
        n_res   = (r_rem2 >= 32'(PRIME_MOD)) ? VAL_W'(r_rem2 - 32'(PRIME_MOD))
                                             : VAL_W'(r_rem2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_q    <= n_q;
        r_plo  <= n_plo;
        r_rem  <= n_rem;
        r_rem2 <= n_rem2;
        r_res  <= n_res;
    end

    assign o_done = r_vld[4];
    assign o_res  = r_res;

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##5 o_done)
        else $error("mulmod result did not appear five cycles after start");

    a_barrett_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_rem < BARRETT_LIMIT))
        else $error("barrett remainder exceeds three times the modulus");

    a_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res < PRIME_MOD))
        else $error("mulmod result not fully reduced");

endmodule

// ===== design/bmp_datapath.sv =====
module bmp_datapath
    import bmp_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_op              i_op,
    input  logic [N_W-1:0]   i_n,
    input  logic [N_W-1:0]   i_k,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [VAL_W-1:0] o_value,
    output logic [ST_W-1:0]  o_status
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int BW = $clog2(TABLE_DEPTH + 1);

    // request registers
    t_op            r_op, n_op;
    logic [N_W-1:0] r_n, n_n;
    logic [N_W-1:0] r_k, n_k;

    // build and query working registers
    logic [AW-1:0]        r_top, n_top;
    logic [AW-1:0]        r_idx, n_idx;
    logic [BW-1:0]        r_built, n_built;
    logic [EXP_BIT_W-1:0] r_bit, n_bit;
    logic [VAL_W-1:0]     r_acc, n_acc;
    logic [VAL_W-1:0]     r_base, n_base;
    logic [VAL_W-1:0]     r_res_value, n_res_value;
    t_status              r_res_status, n_res_status;

    // output register
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_out_value, n_out_value;
    logic [ST_W-1:0]  r_out_status, n_out_status;

    logic [AW-1:0]    w_top;
    logic             w_n_beyond;
    logic             w_k_gt_n;
    logic [VAL_W-1:0] w_mul_a, w_mul_b, w_mul_res;
    logic             w_mul_done;

    logic             w_fact_we, w_inv_we;
    logic [AW-1:0]    w_fact_waddr, w_inv_waddr, w_fact_raddr, w_inv_raddr;
    logic [VAL_W-1:0] w_fact_wdata, w_inv_wdata, w_fact_rdata, w_inv_rdata;

    assign w_top = (32'(r_n) > 32'(TABLE_DEPTH - 1)) ? AW'(TABLE_DEPTH - 1) : AW'(r_n);
    assign w_n_beyond = 32'(r_n) >= 32'(r_built);
    assign w_k_gt_n   = r_k > r_n;

    always_comb begin
        case (i_cmd.mul_sel)
            MS_ACC_IDX: begin
                w_mul_a = r_acc;
                w_mul_b = VAL_W'(r_idx);
            end
            MS_ACC_BASE: begin
                w_mul_a = r_acc;
                w_mul_b = r_base;
            end
            MS_BASE_BASE: begin
                w_mul_a = r_base;
                w_mul_b = r_base;
            end
            default: begin
                w_mul_a = r_acc;
                w_mul_b = r_base;
            end
        endcase
    end

    bmp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_res   (w_mul_res)
    );

    // memory ports
    always_comb begin
        w_fact_we    = i_cmd.build_init | i_cmd.fact_wr;
        w_fact_waddr = i_cmd.build_init ? '0 : r_idx;
        w_fact_wdata = i_cmd.build_init ? VAL_W'(1) : w_mul_res;
        w_inv_we     = i_cmd.inv_init | i_cmd.inv_wr;
        w_inv_waddr  = i_cmd.inv_init ? r_top : r_idx - AW'(1);
        w_inv_wdata  = i_cmd.inv_init ? r_acc : w_mul_res;
        w_fact_raddr = AW'(r_n);
        w_inv_raddr  = i_cmd.q_read_a ? AW'(r_k) : AW'(r_n - r_k);
    end

    bmp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_fact_ram (
        .i_clk   (i_clk),
        .i_we    (w_fact_we),
        .i_waddr (w_fact_waddr),
        .i_wdata (w_fact_wdata),
        .i_raddr (w_fact_raddr),
        .o_rdata (w_fact_rdata)
    );

    bmp_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_DEPTH)) u_inv_ram (
        .i_clk   (i_clk),
        .i_we    (w_inv_we),
        .i_waddr (w_inv_waddr),
        .i_wdata (w_inv_wdata),
        .i_raddr (w_inv_raddr),
        .o_rdata (w_inv_rdata)
    );

    always_comb begin
        n_op         = r_op;
        n_n          = r_n;
        n_k          = r_k;
        n_top        = r_top;
        n_idx        = r_idx;
        n_built      = r_built;
        n_bit        = r_bit;
        n_acc        = r_acc;
        n_base       = r_base;
        n_res_value  = r_res_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;

        if (i_cmd.load_req) begin
            n_op = i_op;
            n_n  = i_n;
            n_k  = i_k;
        end

        if (i_cmd.decode) begin
            n_res_value = '0;
            if (r_op == OP_BUILD) begin
                n_res_status = ST_OK;
            end else if (w_n_beyond) begin
                n_res_status = ST_NOT_BUILT;
            end else if (w_k_gt_n) begin
                n_res_status = ST_K_GT_N;
            end else begin
                n_res_status = ST_OK;
            end
        end
        if (i_cmd.set_value) begin
            n_res_value = w_mul_res;
        end

        if (i_cmd.build_init) begin
            n_top   = w_top;
            n_built = BW'(32'(w_top) + 32'd1);
        end

        // index counter
        if (i_cmd.build_init) begin
            n_idx = AW'(1);
        end else if (i_cmd.inv_init) begin
            n_idx = r_top;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + AW'(1);
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - AW'(1);
        end

        // exponent bit counter
        if (i_cmd.exp_init) begin
            n_bit = '0;
        end else if (i_cmd.bit_inc) begin
            n_bit = r_bit + EXP_BIT_W'(1);
        end

        // accumulator
        if (i_cmd.build_init || i_cmd.exp_init) begin
            n_acc = VAL_W'(1);
        end else if (i_cmd.acc_mul) begin
            n_acc = w_mul_res;
        end else if (i_cmd.q_read_b) begin
            n_acc = w_fact_rdata;
        end

        // base / second operand
        if (i_cmd.exp_init) begin
            n_base = r_acc;
        end else if (i_cmd.base_mul) begin
            n_base = w_mul_res;
        end else if (i_cmd.q_read_b || i_cmd.q_cap_base) begin
            n_base = w_inv_rdata;
        end

        if (i_cmd.push_out) begin
            n_out_valid  = 1'b1;
            n_out_value  = r_res_value;
            n_out_status = r_res_status;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_built     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_n          <= n_n;
        r_k          <= n_k;
        r_top        <= n_top;
        r_idx        <= n_idx;
        r_bit        <= n_bit;
        r_acc        <= n_acc;
        r_base       <= n_base;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_comb begin
        o_sts.op_query     = (r_op == OP_QUERY);
        o_sts.n_beyond     = w_n_beyond;
        o_sts.k_gt_n       = w_k_gt_n;
        o_sts.req_top_zero = (w_top == '0);
        o_sts.top_zero     = (r_top == '0);
        o_sts.idx_eq_top   = (r_idx == r_top);
        o_sts.idx_is_one   = (r_idx == AW'(1));
        o_sts.exp_bit      = FERMAT_EXP[r_bit];
        o_sts.bit_last     = (r_bit == EXP_BIT_W'(EXP_BITS - 1));
        o_sts.mul_done     = w_mul_done;
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_status    = r_out_status;

endmodule

// ===== design/bmp_ctrl.sv =====
module bmp_ctrl
    import bmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.op_query) begin
                    n_state = i_sts.req_top_zero ? S_EXP_INIT : S_FACT_ISSUE;
                end else if (i_sts.n_beyond || i_sts.k_gt_n) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_Q_READ_A;
                end
            end
            S_FACT_ISSUE: n_state = S_FACT_WAIT;
            S_FACT_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = i_sts.idx_eq_top ? S_EXP_INIT : S_FACT_ISSUE;
                end
            end
            S_EXP_INIT: n_state = S_EXP_TEST;
            S_EXP_TEST: n_state = i_sts.exp_bit ? S_EMUL_ISSUE : S_ESQR_ISSUE;
            S_EMUL_ISSUE: n_state = S_EMUL_WAIT;
            S_EMUL_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = S_ESQR_ISSUE;
                end
            end
            S_ESQR_ISSUE: n_state = S_ESQR_WAIT;
            S_ESQR_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = i_sts.bit_last ? S_INV_INIT : S_EXP_TEST;
                end
            end
            S_INV_INIT: n_state = i_sts.top_zero ? S_FINISH : S_INV_ISSUE;
            S_INV_ISSUE: n_state = S_INV_WAIT;
            S_INV_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = i_sts.idx_is_one ? S_FINISH : S_INV_ISSUE;
                end
            end
            S_Q_READ_A: n_state = S_Q_READ_B;
            S_Q_READ_B: n_state = S_Q_MUL1_ISSUE;
            S_Q_MUL1_ISSUE: n_state = S_Q_MUL1_WAIT;
            S_Q_MUL1_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = S_Q_MUL2_ISSUE;
                end
            end
            S_Q_MUL2_ISSUE: n_state = S_Q_MUL2_WAIT;
            S_Q_MUL2_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.mul_sel = MS_ACC_BASE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.load_req = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.decode     = 1'b1;
                o_cmd.build_init = !i_sts.op_query;
            end
            S_FACT_ISSUE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_ACC_IDX;
            end
            S_FACT_WAIT: begin
                o_cmd.acc_mul = i_sts.mul_done;
                o_cmd.fact_wr = i_sts.mul_done;
                o_cmd.idx_inc = i_sts.mul_done;
            end
            S_EXP_INIT: o_cmd.exp_init = 1'b1;
            S_EXP_TEST: ;
            S_EMUL_ISSUE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_ACC_BASE;
            end
            S_EMUL_WAIT: o_cmd.acc_mul = i_sts.mul_done;
            S_ESQR_ISSUE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_BASE_BASE;
            end
            S_ESQR_WAIT: begin
                o_cmd.base_mul = i_sts.mul_done;
                o_cmd.bit_inc  = i_sts.mul_done && !i_sts.bit_last;
            end
            S_INV_INIT: o_cmd.inv_init = 1'b1;
            S_INV_ISSUE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_ACC_IDX;
            end
            S_INV_WAIT: begin
                o_cmd.acc_mul = i_sts.mul_done;
                o_cmd.inv_wr  = i_sts.mul_done;
                o_cmd.idx_dec = i_sts.mul_done;
            end
            S_Q_READ_A: o_cmd.q_read_a = 1'b1;
            S_Q_READ_B: o_cmd.q_read_b = 1'b1;
            S_Q_MUL1_ISSUE: begin
                o_cmd.mul_start  = 1'b1;
                o_cmd.mul_sel    = MS_ACC_BASE;
                o_cmd.q_cap_base = 1'b1;
            end
            S_Q_MUL1_WAIT: o_cmd.acc_mul = i_sts.mul_done;
            S_Q_MUL2_ISSUE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MS_ACC_BASE;
            end
            S_Q_MUL2_WAIT: o_cmd.set_value = i_sts.mul_done;
            S_FINISH: o_cmd.push_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

// ===== design/binomial_mod_prime_table.sv =====
// binomial coefficients mod 998244353 served from factorial tables
// input stream: a build request (tuser 0) fills factorials 0..count_n and their
//   inverses, clamped to TABLE_DEPTH-1; a query request (tuser 1) returns
//   C(count_n, choose_k) mod p, or status 1 when count_n is not built,
//   status 2 when choose_k > count_n (the built check wins)
// output stream: exactly one response per request, in request order; a build
//   answers value 0, status 0 once the tables are complete
// one request is worked on at a time; tready is high only while idle
// each step waits on the pipelined modular multiplier, used one
//   product at a time (issue, then wait for its done):
//   query: two table reads, then two products, from accept to response
//   error: answered straight from decode, with no table read or product
//   build of top entries: top products forward, one fermat inversion
//   (30 exponent bits, 28 of them set) and top products backward
// reset clears the built count (queries report status 1 until a build) and
//   the output valid flag; table memories need no clearing pass
// when the receiver stalls, the finished response waits in the output register
//   while the block accepts the next request; a later response waits in the
//   final state until that register is taken
module binomial_mod_prime_table
    import bmp_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // [11:0] count_n, [23:12] choose_k
    input  logic        i_s_axis_tuser,  // [0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // [29:0] value, [31:30] status
);

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [VAL_W-1:0] w_value;
    logic [ST_W-1:0]  w_status;

    // sequencing of build and query steps
    bmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // tables, multiplier and response register
    bmp_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (t_op'(i_s_axis_tuser)),
        .i_n         (i_s_axis_tdata[N_W-1:0]),
        .i_k         (i_s_axis_tdata[2*N_W-1:N_W]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_value     (w_value),
        .o_status    (w_status)
    );

    // response packing, value in the low bits
    assign o_m_axis_tdata = {w_status, w_value};

endmodule
